/* src/tilt_kalman_filter_two_axis_core_defines.svh */
// assertion macros for the tilt filter
`ifndef TILT_KALMAN_FILTER_TWO_AXIS_CORE_DEFINES_SVH
`define TILT_KALMAN_FILTER_TWO_AXIS_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define TKF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define TKF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* src/tkf_pkg.sv */
// shared types, constants and arithmetic helpers of the tilt filter
`timescale 1ns / 1ps
package tkf_pkg;
    localparam int AXES_DEF = 2;
    localparam int CFG_W = 31;
    localparam int CFG_IDX_W = 2;
    localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_NOISE = 2'd0,
        REG_BIAS_NOISE = 2'd1,
        REG_MEAS_NOISE = 2'd2,
        REG_SAMPLE_PERIOD = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] meas_angle_a;
        logic signed [31:0] rate_a;
        logic signed [31:0] meas_angle_b;
        logic signed [31:0] rate_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] angle_a;
        logic signed [31:0] angle_b;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] qa;
        logic [CFG_W-1:0] qb;
        logic [CFG_W-1:0] r;
        logic [CFG_W-1:0] dt;
    } cfg_t;

    // lane handshake: start pulse in, done pulse and busy level out
    typedef struct packed {
        logic start;
        logic done;
        logic busy;
    } lane_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fff_ffff;
        else if (v < -66'sd2147483648) return 32'sh8000_0000;
        else return v[31:0];
    endfunction

    // rounded q8.24 scaling of a 64-bit product, floor after adding half
    function automatic logic signed [65:0] rnd24(input logic signed [63:0] p);
        logic signed [65:0] s;
        s = 66'(p) + 66'sd8388608;
        return s >>> 24;
    endfunction
endpackage

/* src/tkf_lane.sv */
// one axis: two-state kalman update with shared multiplier and serial divider
`timescale 1ns / 1ps
`include "tilt_kalman_filter_two_axis_core_defines.svh"
module tkf_lane
    import tkf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cfg_t               cfg,
    input  logic signed [31:0] meas,
    input  logic signed [31:0] rate,
    output logic               done,
    output logic               busy,
    output logic signed [31:0] angle
);
    typedef enum logic [4:0] {
        S_IDLE, S_R, S_M_ANG, S_M01, S_M10, S_M11, S_PRED, S_DIV0, S_DIV1,
        S_E, S_M_K0E, S_M_K1E, S_M_K0P00, S_M_K0P01, S_M_K1P00, S_M_K1P01,
        S_DONE
    } st_t;

    st_t st_reg;
    logic signed [31:0] ang_reg, bias_reg, p00s_reg, p01s_reg, p10s_reg, p11s_reg;
    logic signed [31:0] r_reg, a_reg, q00_reg, q01_reg, q10_reg, q11_reg;
    logic signed [31:0] k0_reg, k1_reg, e_reg, mul_a_reg, mul_b_reg;
    // measured angle held for the whole update
    logic signed [31:0] meas_reg;
    logic signed [65:0] t01_reg, t10_reg;
    logic signed [63:0] prod;
    logic signed [65:0] pr;
    // restoring divider
    logic [63:0] rem_reg;
    logic [56:0] quo_reg;
    logic [56:0] dvd_reg;
    logic [32:0] dvs_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic signed [32:0] den;
    logic [63:0] rem_sh;
    logic [57:0] quo_full;

    assign prod = mul_a_reg * mul_b_reg;
    assign pr = rnd24(prod);
    assign den = 33'(q00_reg) + 33'($signed({1'b0, cfg.r}));
    assign rem_sh = {rem_reg[62:0], dvd_reg[56]};
    assign quo_full = {1'b0, quo_reg};
    assign busy = (st_reg != S_IDLE);
    assign angle = ang_reg;

    // magnitude of num*2^24, the dividend of a division by den
    function automatic logic [56:0] mag57(input logic signed [31:0] n);
        logic [31:0] m;
        m = n[31] ? 32'(-n) : n;
        return {1'b0, m, 24'd0};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            done <= 1'b0;
            ang_reg <= '0;
            bias_reg <= '0;
            p00s_reg <= ONE_Q24;
            p01s_reg <= '0;
            p10s_reg <= '0;
            p11s_reg <= ONE_Q24;
        end
        else
        begin
            done <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        r_reg <= sat32(66'(rate) - 66'(bias_reg));
                        meas_reg <= meas;
                        st_reg <= S_R;
                    end
                end
                S_R:
                begin
                    mul_a_reg <= r_reg;
                    mul_b_reg <= $signed({1'b0, cfg.dt});
                    st_reg <= S_M_ANG;
                end
                S_M_ANG:
                begin
                    a_reg <= sat32(66'(ang_reg) + pr);
                    mul_a_reg <= p01s_reg;
                    st_reg <= S_M01;
                end
                S_M01:
                begin
                    t01_reg <= pr;
                    mul_a_reg <= p10s_reg;
                    st_reg <= S_M10;
                end
                S_M10:
                begin
                    t10_reg <= pr;
                    mul_a_reg <= p11s_reg;
                    st_reg <= S_M11;
                end
                S_M11:
                begin
                    q00_reg <= sat32(66'(p00s_reg) + 66'($signed({1'b0, cfg.qa}))
                                     - t01_reg - t10_reg);
                    q01_reg <= sat32(66'(p01s_reg) - pr);
                    q10_reg <= sat32(66'(p10s_reg) - pr);
                    q11_reg <= sat32(66'(p11s_reg) + 66'($signed({1'b0, cfg.qb})));
                    st_reg <= S_PRED;
                end
                S_PRED:
                begin
                    e_reg <= sat32(66'(meas_reg) - 66'(a_reg));
                    dvd_reg <= mag57(q00_reg);
                    dvs_reg <= den[32] ? 33'(-den) : 33'(den);
                    neg_reg <= q00_reg[31] ^ den[32];
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= '0;
                    st_reg <= S_DIV0;
                end
                S_DIV0, S_DIV1:
                begin
                    if (den == '0)
                    begin
                        k0_reg <= '0;
                        k1_reg <= '0;
                        st_reg <= S_E;
                    end
                    else if (cnt_reg == 6'd57)
                    begin
                        if (st_reg == S_DIV0)
                        begin
                            k0_reg <= sat32(neg_reg ? -66'(quo_full) : 66'(quo_full));
                            dvd_reg <= mag57(q10_reg);
                            neg_reg <= q10_reg[31] ^ den[32];
                            rem_reg <= '0;
                            quo_reg <= '0;
                            cnt_reg <= '0;
                            st_reg <= S_DIV1;
                        end
                        else
                        begin
                            k1_reg <= sat32(neg_reg ? -66'(quo_full) : 66'(quo_full));
                            st_reg <= S_E;
                        end
                    end
                    else
                    begin
                        dvd_reg <= {dvd_reg[55:0], 1'b0};
                        if (rem_sh >= 64'(dvs_reg))
                        begin
                            rem_reg <= rem_sh - 64'(dvs_reg);
                            quo_reg <= {quo_reg[55:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[55:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_E:
                begin
                    mul_a_reg <= k0_reg;
                    mul_b_reg <= e_reg;
                    st_reg <= S_M_K0E;
                end
                S_M_K0E:
                begin
                    ang_reg <= sat32(66'(a_reg) + pr);
                    mul_a_reg <= k1_reg;
                    st_reg <= S_M_K1E;
                end
                S_M_K1E:
                begin
                    bias_reg <= sat32(66'(bias_reg) + pr);
                    mul_a_reg <= k0_reg;
                    mul_b_reg <= q00_reg;
                    st_reg <= S_M_K0P00;
                end
                S_M_K0P00:
                begin
                    p00s_reg <= sat32(66'(q00_reg) - pr);
                    mul_b_reg <= q01_reg;
                    st_reg <= S_M_K0P01;
                end
                S_M_K0P01:
                begin
                    p01s_reg <= sat32(66'(q01_reg) - pr);
                    mul_a_reg <= k1_reg;
                    mul_b_reg <= q00_reg;
                    st_reg <= S_M_K1P00;
                end
                S_M_K1P00:
                begin
                    p10s_reg <= sat32(66'(q10_reg) - pr);
                    mul_b_reg <= q01_reg;
                    st_reg <= S_M_K1P01;
                end
                S_M_K1P01:
                begin
                    p11s_reg <= sat32(66'(q11_reg) - pr);
                    st_reg <= S_DONE;
                end
                S_DONE:
                begin
                    done <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    `TKF_ASSERT_NXT(a_start_leaves_idle, clk, rst_n, start && st_reg == S_IDLE, st_reg == S_R,
        "lane did not start")
    `TKF_ASSERT_IMP(a_div_count, clk, rst_n, st_reg == S_DIV0 || st_reg == S_DIV1,
        cnt_reg <= 6'd57, "divider count out of range")
    `TKF_ASSERT_IMP(a_done_idle, clk, rst_n, done, st_reg == S_IDLE, "done outside idle")
endmodule

/* src/tilt_kalman_filter_two_axis_core.sv */
// top level of the two-axis tilt kalman filter
//
//  channel | signals                     | moves
//  --------+-----------------------------+----------------------------------
//  in      | in_valid, in_ready, in_data | one request: angle and rate per axis
//  out     | out_valid, out_ready, out_data | filtered angles
//  cfg     | cfg_we, cfg_idx, cfg_data   | register write, no wait
//
// a result is valid once each lane has run its two serial divisions and the merge
// stage has registered it; both divisions are skipped when the gain denominator is zero
// all lanes run side by side, the merge stage packs the angles of lanes 0 and 1 into one result
// a result waits in the output register; the next request is taken only once
// it has been delivered, since each axis state feeds the next update
// reset clears state to zero angle and bias and unit covariance, no clearing pass
`timescale 1ns / 1ps
`include "tilt_kalman_filter_two_axis_core_defines.svh"
module tilt_kalman_filter_two_axis_core
    import tkf_pkg::*;
#(
    parameter int AXES = AXES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data
);
    cfg_t cfg_reg;
    logic [AXES-1:0] done_vec, busy_vec;
    logic signed [31:0] lane_ang [AXES];
    logic signed [31:0] lane_meas [AXES];
    logic signed [31:0] lane_rate [AXES];
    logic active_reg;
    lane_ctl_t ctl;
    logic in_acc;
    logic signed [31:0] in_words [4];

    assign in_acc = in_valid && in_ready;
    // idle when no lane works and no result is pending
    assign in_ready = !active_reg && !out_valid;
    assign ctl.start = in_acc;
    assign ctl.done = done_vec[0];
    assign ctl.busy = |busy_vec;

    assign in_words[0] = in_data.meas_angle_a;
    assign in_words[1] = in_data.rate_a;
    assign in_words[2] = in_data.meas_angle_b;
    assign in_words[3] = in_data.rate_b;

    // config register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.qa <= 31'd5033;
            cfg_reg.qb <= 31'd15099;
            cfg_reg.r <= 31'd13421773;
            cfg_reg.dt <= 31'd83886;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                REG_ANGLE_NOISE:   cfg_reg.qa <= cfg_data;
                REG_BIAS_NOISE:    cfg_reg.qb <= cfg_data;
                REG_MEAS_NOISE:    cfg_reg.r <= cfg_data;
                REG_SAMPLE_PERIOD: cfg_reg.dt <= cfg_data;
                default: ;
            endcase
        end
    end

    // lanes; axes past the two carried fields see zero input
    for (genvar k = 0; k < AXES; k++)
    begin : g_lane
        if (k < 2)
        begin : g_src
            assign lane_meas[k] = in_words[2*k];
            assign lane_rate[k] = in_words[2*k+1];
        end
        else
        begin : g_zero
            assign lane_meas[k] = '0;
            assign lane_rate[k] = '0;
        end
        tkf_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (ctl.start),
            .cfg   (cfg_reg),
            .meas  (lane_meas[k]),
            .rate  (lane_rate[k]),
            .done  (done_vec[k]),
            .busy  (busy_vec[k]),
            .angle (lane_ang[k])
        );
    end

    // merge stage: collect lane angles into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (ctl.start)
                active_reg <= 1'b1;
            else if (ctl.done)
            begin
                active_reg <= 1'b0;
                out_valid <= 1'b1;
                out_data.angle_a <= lane_ang[0];
                out_data.angle_b <= (AXES > 1) ? lane_ang[AXES > 1 ? 1 : 0] : '0;
            end
            if (out_valid && out_ready)
                out_valid <= 1'b0;
        end
    end

    `TKF_ASSERT_IMP(a_lanes_lockstep, clk, rst_n, 1'b1,
        done_vec == '0 || done_vec == '1, "lanes out of step")
    `TKF_ASSERT_IMP(a_no_accept_busy, clk, rst_n, in_acc, !ctl.busy && !out_valid,
        "request taken while busy")
    `TKF_ASSERT_NXT(a_done_gives_result, clk, rst_n, ctl.done, out_valid,
        "finished lanes left no result")
endmodule
